### rtl/sihd_pkg.sv
// Shared constants and types for the string intern dictionary.
package sihd_pkg;
  localparam int unsigned Slots      = 1024;
  localparam int unsigned MaxEntries = 768;
  localparam int unsigned ArenaBytes = 16384;
  localparam int unsigned MaxKeyLen  = 64;
  localparam int unsigned SlotW  = $clog2(Slots);
  localparam int unsigned IdW    = $clog2(MaxEntries);
  localparam int unsigned CntW   = $clog2(MaxEntries + 1);
  localparam int unsigned ArenaW = $clog2(ArenaBytes);
  localparam int unsigned UsedW  = $clog2(ArenaBytes + 1);
  localparam int unsigned KeyW   = $clog2(MaxKeyLen);
  localparam int unsigned KlenW  = $clog2(MaxKeyLen + 1);
  localparam int unsigned ProbeW = $clog2(Slots + 1);
  localparam logic [63:0] HashBasis = 64'd1469598103934665603;
  localparam logic [63:0] HashPrime = 64'd1099511628211;
  localparam logic [SlotW-1:0] HashInit = HashBasis[SlotW-1:0];
  localparam logic [SlotW-1:0] HashMul  = HashPrime[SlotW-1:0];

  localparam logic [1:0] StFound    = 2'd0;
  localparam logic [1:0] StInserted = 2'd1;
  localparam logic [1:0] StAbsent   = 2'd2;
  localparam logic [1:0] StRejected = 2'd3;

  typedef struct packed {
    logic       action;
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdW-1:0]  entry_id;
    logic [CntW-1:0] entry_count;
  } out_t;
endpackage

### rtl/sihd_if.sv
// Valid/ready channel interfaces.
interface sihd_in_if import sihd_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sihd_out_if import sihd_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/sihd_ram.sv
// Generic single-port-write, one-read synchronous RAM.
module sihd_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

### rtl/string_intern_hash_dictionary_unit.sv
// Top level of the string intern dictionary.
// Keys stream in one byte per transaction. After reset the slot table is
// swept clear before the first transaction is taken. On the last byte the
// sequencer walks the probe chain, unless the key overflowed. For each
// occupied slot it reads the slot and then its descriptor; when the lengths
// agree it compares the key against the arena byte by byte, and a full match
// ends the walk. An empty slot ends the walk. An insert copies the key into
// the arena at one byte per cycle. The result register is then loaded in the
// done state once any earlier result has left it. A result still waiting on
// the sink does not hold byte transactions; the next lookup holds its own
// result until the sink takes the waiting one. The memory reads set the pace;
// bytes of a new key are not taken until the previous key is done.
module string_intern_hash_dictionary_unit import sihd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  sihd_in_if.sink    in_i,
  sihd_out_if.source out_o
);
  localparam logic [3:0] SClr = 4'd0, SIdle = 4'd1, SSlotRd = 4'd2, SSlotWt = 4'd3,
    SEntWt = 4'd4, SCmpRd = 4'd5, SCmpWt = 4'd6, SCopy = 4'd7, SDone = 4'd8;

  logic [3:0] state_q;
  logic [KlenW-1:0] klen_q;
  logic ovf_q, act_q;
  logic [SlotW-1:0] hash_q, idx_q;
  logic [ProbeW-1:0] nprobe_q;
  logic [KlenW-1:0] k_q;
  logic [UsedW-1:0] used_q;
  logic [CntW-1:0] cnt_q;
  logic [IdW-1:0] cid_q;
  logic [ArenaW:0] off_q;
  logic [1:0] st_q;
  logic [IdW-1:0] rid_q;
  out_t res_q;
  logic res_v_q;

  // key buffer
  logic kb_we;
  logic [KeyW-1:0] kb_wa, kb_ra;
  logic [7:0] kb_rd;
  sihd_ram #(.Depth(MaxKeyLen), .Width(8)) u_kbuf (
    .clk_i, .we_i(kb_we), .waddr_i(kb_wa), .wdata_i(in_i.data.key_byte),
    .raddr_i(kb_ra), .rdata_o(kb_rd));

  // slot table
  logic sl_we;
  logic [SlotW-1:0] sl_wa;
  logic [IdW:0] sl_wd, sl_rd;
  sihd_ram #(.Depth(Slots), .Width(IdW+1)) u_slot (
    .clk_i, .we_i(sl_we), .waddr_i(sl_wa), .wdata_i(sl_wd),
    .raddr_i(idx_q), .rdata_o(sl_rd));

  // entry descriptors: offset and length
  logic en_we;
  logic [IdW-1:0] en_ra;
  logic [ArenaW+KlenW-1:0] en_rd;
  sihd_ram #(.Depth(MaxEntries), .Width(ArenaW+KlenW)) u_ent (
    .clk_i, .we_i(en_we), .waddr_i(cnt_q[IdW-1:0]),
    .wdata_i({used_q[ArenaW-1:0], klen_q}), .raddr_i(en_ra), .rdata_o(en_rd));

  // arena
  logic ar_we;
  logic [ArenaW-1:0] ar_wa, ar_ra;
  logic [7:0] ar_rd;
  sihd_ram #(.Depth(ArenaBytes), .Width(8)) u_arena (
    .clk_i, .we_i(ar_we), .waddr_i(ar_wa), .wdata_i(kb_rd),
    .raddr_i(ar_ra), .rdata_o(ar_rd));

  logic acc_in;
  logic byte_take;
  logic [SlotW-1:0] hx;
  logic [2*SlotW-1:0] hprod;
  logic [IdW-1:0] sid;
  logic sl_occ;
  logic [ArenaW:0] at;
  logic can_ins;

  assign in_i.ready = (state_q == SIdle);
  assign acc_in = in_i.valid && in_i.ready;
  assign byte_take = acc_in && in_i.data.byte_valid && (klen_q < KlenW'(MaxKeyLen));
  assign hx = hash_q ^ SlotW'(in_i.data.key_byte);
  assign hprod = hx * HashMul;
  assign kb_we = byte_take;
  assign kb_wa = klen_q[KeyW-1:0];
  assign sid = sl_rd[IdW-1:0] - IdW'(1);
  assign sl_occ = (sl_rd != '0);
  assign en_ra = sid;
  assign at = off_q + (ArenaW+1)'(k_q);
  assign ar_ra = at[ArenaW-1:0];
  assign kb_ra = k_q[KeyW-1:0];
  assign can_ins = ((32'(cnt_q) + 32'd1) * 32'd4 <= 32'(Slots) * 32'd3) &&
                   (32'(cnt_q) < 32'(MaxEntries)) &&
                   (32'(used_q) + 32'(klen_q) <= 32'(ArenaBytes));

  logic copy_wr_q;
  logic [ArenaW-1:0] copy_wa_q;
  assign ar_we = copy_wr_q;
  assign ar_wa = copy_wa_q;
  assign sl_we = (state_q == SClr) || (state_q == SDone && st_q == StInserted && !res_v_q);
  assign sl_wa = (state_q == SClr) ? nprobe_q[SlotW-1:0] : idx_q;
  assign sl_wd = (state_q == SClr) ? '0 : {1'b0, cnt_q[IdW-1:0]} + (IdW+1)'(1);
  assign en_we = (state_q == SDone) && (st_q == StInserted) && !res_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      klen_q <= '0; ovf_q <= 1'b0; act_q <= 1'b0;
      hash_q <= HashInit; idx_q <= '0; nprobe_q <= '0; k_q <= '0;
      used_q <= '0; cnt_q <= '0; cid_q <= '0; off_q <= '0;
      st_q <= StFound; rid_q <= '0; res_v_q <= 1'b0; copy_wr_q <= 1'b0;
      copy_wa_q <= '0; res_q <= '0;
    end else begin
      copy_wr_q <= 1'b0;
      if (res_v_q && out_o.ready) res_v_q <= 1'b0;
      case (state_q)
        SClr: begin
          nprobe_q <= nprobe_q + ProbeW'(1);
          if (nprobe_q == ProbeW'(Slots - 1)) state_q <= SIdle;
        end
        SIdle: begin
          if (acc_in) begin
            if (byte_take) begin
              klen_q <= klen_q + KlenW'(1);
              hash_q <= hprod[SlotW-1:0];
            end else if (in_i.data.byte_valid) begin
              ovf_q <= 1'b1;
            end
            if (in_i.data.last_byte) begin
              act_q <= in_i.data.action;
              nprobe_q <= '0;
              if (byte_take) idx_q <= hprod[SlotW-1:0];
              else idx_q <= hash_q;
              if (ovf_q || (in_i.data.byte_valid && !byte_take)) begin
                st_q <= in_i.data.action ? StAbsent : StRejected;
                state_q <= SDone;
              end else begin
                state_q <= SSlotRd;
              end
            end
          end
        end
        SSlotRd: state_q <= SSlotWt;
        SSlotWt: begin
          if (!sl_occ) begin
            if (act_q) st_q <= StAbsent;
            else if (can_ins) begin
              st_q <= StInserted; k_q <= '0; state_q <= SCopy;
            end else st_q <= StRejected;
            if (act_q || !can_ins) state_q <= SDone;
          end else begin
            cid_q <= sid; state_q <= SEntWt;
          end
        end
        SEntWt: begin
          k_q <= '0;
          // all-ones offset marks a failed candidate
          if (32'(cid_q) >= 32'(MaxEntries) || en_rd[KlenW-1:0] != klen_q) begin
            off_q <= '1;
            state_q <= SCmpWt;
          end else begin
            off_q <= {1'b0, en_rd[ArenaW+KlenW-1:KlenW]};
            state_q <= SCmpRd;
          end
        end
        SCmpRd: begin
          if (k_q == klen_q) begin
            st_q <= StFound; rid_q <= cid_q; state_q <= SDone;
          end else if (at[ArenaW]) begin
            state_q <= SCmpWt; off_q <= '1;
          end else state_q <= SCmpWt;
        end
        SCmpWt: begin
          // off_q all ones marks a failed candidate
          if (off_q == '1 || ar_rd != kb_rd) begin
            nprobe_q <= nprobe_q + ProbeW'(1);
            idx_q <= idx_q + SlotW'(1);
            if (nprobe_q == ProbeW'(Slots - 1)) begin
              st_q <= act_q ? StAbsent : StRejected;
              state_q <= SDone;
            end else state_q <= SSlotRd;
          end else begin
            k_q <= k_q + KlenW'(1);
            state_q <= SCmpRd;
          end
        end
        SCopy: begin
          if (k_q == klen_q) begin
            state_q <= SDone;
          end else begin
            copy_wr_q <= 1'b1;
            copy_wa_q <= ArenaW'(used_q + UsedW'(k_q));
            k_q <= k_q + KlenW'(1);
          end
        end
        SDone: begin
          // wait until the previous result has left the output register
          if (!res_v_q) begin
            res_q.status <= st_q;
            res_q.entry_id <= (st_q == StFound) ? rid_q :
                              (st_q == StInserted) ? cnt_q[IdW-1:0] : '0;
            res_q.entry_count <= (st_q == StInserted) ? cnt_q + CntW'(1) : cnt_q;
            if (st_q == StInserted) begin
              cnt_q <= cnt_q + CntW'(1);
              used_q <= used_q + UsedW'(klen_q);
            end
            res_v_q <= 1'b1;
            klen_q <= '0; ovf_q <= 1'b0; hash_q <= HashInit;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_o.valid = res_v_q;
  assign out_o.data = res_q;
endmodule
